/* rtl/core/cosine_similarity_engine_defines.svh */
`ifndef COSINE_SIMILARITY_ENGINE_DEFINES_SVH
`define COSINE_SIMILARITY_ENGINE_DEFINES_SVH

// clocked check on i_clk, masked while i_rst_n is low
`define CSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define CSE_NEVER(label, cond, msg) \
    `CSE_ASSERT(label, !(cond), msg)

`endif

/* rtl/core/cse_pkg.sv */
`default_nettype none

package cse_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 48;
    localparam int SIM_W    = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SIM_W-1:0]    t_sim;

    // accumulator snapshot of one finished vector pair
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        mag_a;
        logic [ACC_W-1:0]        mag_b;
    } t_acc_set;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* rtl/core/cse_in_if.sv */
`default_nettype none

interface cse_in_if;
    import cse_pkg::*;

    logic    valid;
    logic    ready;
    t_sample elem_a;
    t_sample elem_b;
    logic    is_last;

    modport source (output valid, output elem_a, output elem_b, output is_last, input ready);
    modport sink   (input valid, input elem_a, input elem_b, input is_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/cse_out_if.sv */
`default_nettype none

interface cse_out_if;
    import cse_pkg::*;

    logic valid;
    logic ready;
    t_sim similarity;
    logic degenerate;

    modport source (output valid, output similarity, output degenerate, input ready);
    modport sink   (input valid, input similarity, input degenerate, output ready);
endinterface

`default_nettype wire

/* rtl/core/cosine_similarity_engine.sv */
// flow: a pair goes to the product stage, then into the accumulators; after its last
//   pair a vector passes multiplier, divider and square root (a quotient of one skips
//   the last two, a degenerate one all three), waiting on older vectors or a stalled result
// throughput: one element pair per cycle unless a full queue holds a last pair; one
//   vector at a time on the 8-step shared 24x24 multiplier, restoring divider and root
// reset: synchronous active-low i_rst_n clears accumulators, queue and sequencer state
`default_nettype none

module cosine_similarity_engine #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cse_in_if.sink    i_pair,
    cse_out_if.source o_result
);
    import cse_pkg::*;

    // front to queue: finished accumulator set of one vector pair
    logic     w_push;
    t_acc_set w_push_entry;

    // queue to back
    logic     w_pop;
    t_acc_set w_head_entry;
    t_q_stat  w_q_stat;

    // front: takes one item per cycle unless a full queue holds a last pair; squares and
    // multiplies, saturating accumulate; the last item pushes the accumulator set and clears
    cse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (i_pair),
        .i_stat  (w_q_stat),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // short queue so streaming continues while the back end works on earlier vectors
    cse_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_stat  (w_q_stat)
    );

    // back: exact q = floor(sqrt(dot^2 * 2^30 / (ma*mb))), signed and saturated to Q1.15,
    // held in an output register so the next vector can start meanwhile
    cse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_head_entry),
        .i_stat   (w_q_stat),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* rtl/core/cse_front.sv */
`default_nettype none

module cse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cse_in_if.sink            i_pair,
    input  cse_pkg::t_q_stat  i_stat,
    output logic              o_push,
    output cse_pkg::t_acc_set o_entry
);
    import cse_pkg::*;

    logic signed [PROD_W-1:0] r_p_ab;
    logic signed [PROD_W-1:0] r_p_aa;
    logic signed [PROD_W-1:0] r_p_bb;
    logic                     r_p_last;
    logic                     r_p_vld;
    logic                     n_p_vld;
    logic signed [ACC_W-1:0]  r_dot;
    logic signed [ACC_W-1:0]  n_dot;
    logic signed [ACC_W-1:0]  r_mag_a;
    logic signed [ACC_W-1:0]  n_mag_a;
    logic signed [ACC_W-1:0]  r_mag_b;
    logic signed [ACC_W-1:0]  n_mag_b;
    logic signed [ACC_W-1:0]  w_dot_sum;
    logic signed [ACC_W-1:0]  w_a_sum;
    logic signed [ACC_W-1:0]  w_b_sum;
    logic signed [PROD_W-1:0] w_ab;
    logic signed [PROD_W-1:0] w_aa;
    logic signed [PROD_W-1:0] w_bb;
    logic                     w_stall;
    logic                     w_accept;
    logic                     w_adv;

    // saturating add at the accumulator limits
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    always_comb begin
        w_ab = i_pair.elem_a * i_pair.elem_b;
        w_aa = i_pair.elem_a * i_pair.elem_a;
        w_bb = i_pair.elem_b * i_pair.elem_b;

        // a last pair waits in the product stage while the queue is full
        w_stall      = r_p_vld && r_p_last && i_stat.full;
        i_pair.ready = !w_stall;
        w_accept     = i_pair.valid && !w_stall;
        w_adv        = r_p_vld && !w_stall;

        w_dot_sum = sat_add(r_dot, r_p_ab);
        w_a_sum   = sat_add(r_mag_a, r_p_aa);
        w_b_sum   = sat_add(r_mag_b, r_p_bb);

        n_dot   = r_dot;
        n_mag_a = r_mag_a;
        n_mag_b = r_mag_b;
        if (w_adv) begin
            if (r_p_last) begin
                n_dot   = '0;
                n_mag_a = '0;
                n_mag_b = '0;
            end else begin
                n_dot   = w_dot_sum;
                n_mag_a = w_a_sum;
                n_mag_b = w_b_sum;
            end
        end

        if (w_accept) begin
            n_p_vld = 1'b1;
        end else if (w_adv) begin
            n_p_vld = 1'b0;
        end else begin
            n_p_vld = r_p_vld;
        end

        o_push        = w_adv && r_p_last;
        o_entry.dot   = w_dot_sum;
        o_entry.mag_a = w_a_sum;
        o_entry.mag_b = w_b_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_dot   <= '0;
            r_mag_a <= '0;
            r_mag_b <= '0;
        end else begin
            r_p_vld <= n_p_vld;
            r_dot   <= n_dot;
            r_mag_a <= n_mag_a;
            r_mag_b <= n_mag_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_ab   <= w_ab;
            r_p_aa   <= w_aa;
            r_p_bb   <= w_bb;
            r_p_last <= i_pair.is_last;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cse_queue.sv */
`default_nettype none
`include "cosine_similarity_engine_defines.svh"

module cse_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cse_pkg::t_acc_set i_entry,
    input  logic              i_pop,
    output cse_pkg::t_acc_set o_entry,
    output cse_pkg::t_q_stat  o_stat
);
    import cse_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_acc_set        r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
        o_stat.full  = (r_count == CW'(DEPTH));
        o_stat.empty = (r_count == '0);
        o_entry      = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `CSE_NEVER(a_push_full, i_push && o_stat.full, "push into full queue")
    `CSE_NEVER(a_pop_empty, i_pop && o_stat.empty, "pop from empty queue")
    `CSE_ASSERT(a_count_up, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "count lost a push")

endmodule

`default_nettype wire

/* rtl/core/cse_back.sv */
`default_nettype none
`include "cosine_similarity_engine_defines.svh"

module cse_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cse_pkg::t_acc_set i_entry,
    input  cse_pkg::t_q_stat  i_stat,
    output logic              o_pop,
    cse_out_if.source         o_result
);
    import cse_pkg::*;

    localparam int HALF_W = ACC_W / 2;
    localparam int WIDE_W = 2 * ACC_W;
    localparam int QUO_W  = 2 * (SIM_W - 1);
    localparam int ROOT_W = QUO_W + 1;
    localparam int ONE_W  = QUO_W - 1;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0]  MUL_STEPS = CNT_W'(8);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [ONE_W-1:0]  ONE_INIT  = {1'b1, {(ONE_W-1){1'b0}}};
    localparam logic [ONE_W-1:0]  ONE_LAST  = ONE_W'(1);
    localparam logic [ROOT_W-1:0] Q_FULL    = ROOT_W'(1) << (SIM_W - 1);
    localparam logic [SIM_W-1:0]  SIM_MAX   = {1'b0, {(SIM_W-1){1'b1}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        r_state,   n_state;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    logic [ACC_W-1:0]  r_dot_abs, n_dot_abs;
    logic              r_neg,     n_neg;
    logic              r_dgn,     n_dgn;
    logic [ACC_W-1:0]  r_ma,      n_ma;
    logic [ACC_W-1:0]  r_mb,      n_mb;
    logic [ACC_W-1:0]  r_pp,      n_pp;
    logic [2:0]        r_pp_step, n_pp_step;
    logic              r_pp_vld,  n_pp_vld;
    logic [WIDE_W-1:0] r_sq,      n_sq;
    logic [WIDE_W-1:0] r_prod,    n_prod;
    logic [WIDE_W-1:0] r_rem,     n_rem;
    logic [QUO_W-1:0]  r_quo,     n_quo;
    logic [ROOT_W-1:0] r_res,     n_res;
    logic [ONE_W-1:0]  r_one,     n_one;
    logic              r_out_vld, n_out_vld;
    logic [SIM_W-1:0]  r_out_sim, n_out_sim;
    logic              r_out_dgn, n_out_dgn;

    logic [2:0]        w_step;
    logic [ACC_W-1:0]  w_x_src;
    logic [ACC_W-1:0]  w_y_src;
    logic [HALF_W-1:0] w_x;
    logic [HALF_W-1:0] w_y;
    logic [ACC_W-1:0]  w_pp;
    logic [WIDE_W-1:0] w_pp_wide;
    logic [WIDE_W-1:0] w_pp_sh;
    logic [WIDE_W-1:0] w_rem2;
    logic [ROOT_W-1:0] w_op;
    logic [ROOT_W-1:0] w_trial;
    logic [SIM_W-1:0]  w_q;
    logic              w_slot;
    logic              w_degen;

    always_comb begin
        // shared 24x24 multiplier: four squares-of-dot pieces, then four ma*mb pieces
        w_step  = r_cnt[2:0];
        w_x_src = w_step[2] ? r_ma : r_dot_abs;
        w_y_src = w_step[2] ? r_mb : r_dot_abs;
        w_x     = w_step[1] ? w_x_src[ACC_W-1:HALF_W] : w_x_src[HALF_W-1:0];
        w_y     = w_step[0] ? w_y_src[ACC_W-1:HALF_W] : w_y_src[HALF_W-1:0];
        w_pp    = w_x * w_y;

        w_pp_wide = {{(WIDE_W-ACC_W){1'b0}}, r_pp};
        case (r_pp_step[1:0])
            2'b00:   w_pp_sh = w_pp_wide;
            2'b11:   w_pp_sh = w_pp_wide << (2 * HALF_W);
            default: w_pp_sh = w_pp_wide << HALF_W;
        endcase

        w_rem2  = {r_rem[WIDE_W-2:0], 1'b0};
        w_op    = {1'b0, r_quo};
        w_trial = r_res + ROOT_W'(r_one);
        w_q     = r_res[SIM_W-1:0];
        w_slot  = !r_out_vld || o_result.ready;
        w_degen = (i_entry.mag_a == '0) || (i_entry.mag_b == '0);

        n_state   = r_state;
        n_cnt     = r_cnt;
        n_dot_abs = r_dot_abs;
        n_neg     = r_neg;
        n_dgn     = r_dgn;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_pp      = r_pp;
        n_pp_step = r_pp_step;
        n_pp_vld  = 1'b0;
        n_sq      = r_sq;
        n_prod    = r_prod;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_res     = r_res;
        n_one     = r_one;
        n_out_vld = r_out_vld && !o_result.ready;
        n_out_sim = r_out_sim;
        n_out_dgn = r_out_dgn;
        o_pop     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop     = 1'b1;
                    n_neg     = i_entry.dot[ACC_W-1];
                    n_dot_abs = i_entry.dot[ACC_W-1] ? ACC_W'(-i_entry.dot) : i_entry.dot;
                    n_ma      = i_entry.mag_a;
                    n_mb      = i_entry.mag_b;
                    n_dgn     = w_degen;
                    n_sq      = '0;
                    n_prod    = '0;
                    n_cnt     = '0;
                    n_res     = '0;
                    n_state   = w_degen ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt != MUL_STEPS) begin
                    n_pp      = w_pp;
                    n_pp_step = w_step;
                    n_pp_vld  = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                end else begin
                    n_state = S_CMP;
                end
                if (r_pp_vld) begin
                    if (r_pp_step[2]) begin
                        n_prod = r_prod + w_pp_sh;
                    end else begin
                        n_sq = r_sq + w_pp_sh;
                    end
                end
            end
            S_CMP: begin
                // dot^2 >= ma*mb means the quotient reaches one
                if (r_sq >= r_prod) begin
                    n_res   = Q_FULL;
                    n_state = S_DONE;
                end else begin
                    n_rem   = r_sq;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_res   = '0;
                    n_one   = ONE_INIT;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // one fraction bit of dot^2 / (ma*mb) per cycle
                if (w_rem2 >= r_prod) begin
                    n_rem = w_rem2 - r_prod;
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem2;
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                // bitwise integer square root, one result bit per cycle
                if (w_op >= w_trial) begin
                    n_quo = QUO_W'(w_op - w_trial);
                    n_res = (r_res >> 1) + ROOT_W'(r_one);
                end else begin
                    n_res = r_res >> 1;
                end
                n_one = r_one >> 2;
                if (r_one == ONE_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot) begin
                    n_out_vld = 1'b1;
                    n_out_dgn = r_dgn;
                    if (r_neg) begin
                        n_out_sim = -w_q;
                    end else if (w_q == Q_FULL[SIM_W-1:0]) begin
                        n_out_sim = SIM_MAX;
                    end else begin
                        n_out_sim = w_q;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_result.valid      = r_out_vld;
        o_result.similarity = r_out_sim;
        o_result.degenerate = r_out_dgn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pp_vld  <= n_pp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_dot_abs <= n_dot_abs;
        r_neg     <= n_neg;
        r_dgn     <= n_dgn;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_pp      <= n_pp;
        r_pp_step <= n_pp_step;
        r_sq      <= n_sq;
        r_prod    <= n_prod;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_res     <= n_res;
        r_one     <= n_one;
        r_out_sim <= n_out_sim;
        r_out_dgn <= n_out_dgn;
    end

    `CSE_ASSERT(a_div_rem, (r_state == S_DIV) |-> (r_rem < r_prod), "remainder not below divisor")
    `CSE_ASSERT(a_root_one, (r_state == S_ROOT) |-> $onehot(r_one), "root weight not one-hot")
    `CSE_ASSERT(a_pop_busy, o_pop |=> (r_state != S_IDLE), "pop did not start work")
    `CSE_ASSERT(a_dgn_zero, (o_result.valid && o_result.degenerate) |-> (o_result.similarity == '0), "degenerate item not zero")

endmodule

`default_nettype wire

/* test/cse_result_checker.sv */
module cse_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_done,
    cse_in_if    i_pair,
    cse_out_if   i_result,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_degenerate
);
    import cse_pkg::*;

    typedef struct packed {
        t_sim similarity;
        logic degenerate;
    } t_cos_result;

    localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic signed [ACC_W-1:0] dot_sum;
    logic signed [ACC_W-1:0] mag_a_sum;
    logic signed [ACC_W-1:0] mag_b_sum;
    t_cos_result             cos_queue[$];
    t_cos_result             next_cos;
    t_cos_result             want;
    int                      fail_count;
    int                      checked;
    int                      degen_count;
    int                      pending;
    logic                    done_seen;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_degenerate = degen_count;

    initial begin
        fail_count  = 0;
        checked     = 0;
        degen_count = 0;
        pending     = 0;
        done_seen   = 1'b0;
    end

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // accumulator add, clamped to the 48-bit signed range
    function automatic logic signed [ACC_W-1:0] sum_sat(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        longint s;
        s = longint'(acc) + longint'(prod);
        if (s > ACC_HI)
            s = ACC_HI;
        else if (s < ACC_LO)
            s = ACC_LO;
        return s[ACC_W-1:0];
    endfunction

    // largest q with q^2 * ma * mb <= dot^2 * 2^30, signed like dot, +1 clamped
    function automatic t_sim sim_from_sums(
        input logic signed [ACC_W-1:0] dot,
        input logic [ACC_W-1:0]        ma,
        input logic [ACC_W-1:0]        mb
    );
        logic [63:0]  abs_dot;
        logic [127:0] bound;
        logic [127:0] lhs;
        int           lo;
        int           hi;
        int           mid;
        abs_dot = (dot < 0) ? 64'(-longint'(dot)) : 64'(longint'(dot));
        bound   = (128'(abs_dot) * 128'(abs_dot)) << 30;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = 128'(ma) * 128'(mb) * 128'(unsigned'(mid)) * 128'(unsigned'(mid));
            if (lhs <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (dot < 0)
            return t_sim'(-lo);
        return t_sim'((lo > 32767) ? 32767 : lo);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dot_sum   = '0;
            mag_a_sum = '0;
            mag_b_sum = '0;
            cos_queue.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (cos_queue.size() == 0) begin
                    report($sformatf("result with none pending: similarity %0d degenerate %0b",
                                     i_result.similarity, i_result.degenerate));
                end else begin
                    want = cos_queue.pop_front();
                    checked++;
                    if (want.degenerate)
                        degen_count++;
                    if (i_result.similarity !== want.similarity)
                        report($sformatf("similarity %0d, predicted %0d",
                                         i_result.similarity, want.similarity));
                    if (i_result.degenerate !== want.degenerate)
                        report($sformatf("degenerate %0b, predicted %0b",
                                         i_result.degenerate, want.degenerate));
                end
            end

            if (i_pair.valid && i_pair.ready) begin
                dot_sum   = sum_sat(dot_sum, i_pair.elem_a * i_pair.elem_b);
                mag_a_sum = sum_sat(mag_a_sum, i_pair.elem_a * i_pair.elem_a);
                mag_b_sum = sum_sat(mag_b_sum, i_pair.elem_b * i_pair.elem_b);
                if (i_pair.is_last) begin
                    next_cos.degenerate = (mag_a_sum == 0) || (mag_b_sum == 0);
                    next_cos.similarity = next_cos.degenerate ? '0 :
                        sim_from_sums(dot_sum, mag_a_sum, mag_b_sum);
                    cos_queue.push_back(next_cos);
                    dot_sum   = '0;
                    mag_a_sum = '0;
                    mag_b_sum = '0;
                end
            end

            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (cos_queue.size() != 0)
                    report($sformatf("%0d results never arrived", cos_queue.size()));
            end
        end
        pending = cos_queue.size();
    end

endmodule

/* test/tb.sv */
module tb;
    import cse_pkg::*;

    // shape of the values inside one vector pair
    typedef enum int {
        MODE_RANDOM,
        MODE_SAME,
        MODE_OPPOSITE,
        MODE_NEAR,
        MODE_ZERO_A,
        MODE_ZERO_B,
        MODE_TINY,
        MODE_EXTREME
    } t_vec_mode;

    localparam int PHASE_ITEMS = 275;

    logic clk = 1'b0;
    logic rst_n;
    logic done;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   pairs_sent;
    int   vectors_sent;
    int   fail_count;
    int   pending;
    int   checked;
    int   degen_seen;

    cse_in_if  pair_if ();
    cse_out_if result_if ();

    cosine_similarity_engine i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_pair   (pair_if),
        .o_result (result_if)
    );

    // predicts every result from the accepted pairs and compares
    cse_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_done       (done),
        .i_pair       (pair_if),
        .i_result     (result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_degenerate (degen_seen)
    );

    always #2 clk = ~clk;

    // hard stop far beyond the slowest legal run
    initial begin
        #16000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side back-pressure, redrawn every cycle
    always @(negedge clk) begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one element pair: random idle cycles first, then hold valid until taken
    task automatic put_pair(input t_sample a, input t_sample b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            // garbage on the payload while valid is low
            pair_if.valid   <= 1'b0;
            pair_if.elem_a  <= t_sample'($urandom);
            pair_if.elem_b  <= t_sample'($urandom);
            pair_if.is_last <= 1'($urandom_range(1));
            @(negedge clk);
        end
        pair_if.valid   <= 1'b1;
        pair_if.elem_a  <= a;
        pair_if.elem_b  <= b;
        pair_if.is_last <= last;
        do @(posedge clk); while (!pair_if.ready);
        pairs_sent++;
        if (last)
            vectors_sent++;
        @(negedge clk);
    endtask

    // one full vector pair of the given length, is_last on the final item
    task automatic send_vector(input int len, input t_vec_mode mode);
        t_sample a;
        t_sample b;
        int      s;
        for (int k = 0; k < len; k++) begin
            a = t_sample'($urandom);
            b = t_sample'($urandom);
            case (mode)
                MODE_SAME: begin
                    b = a;
                end
                MODE_OPPOSITE: begin
                    // -(-32768) does not fit, nearest value instead
                    b = (a == -16'sd32768) ? 16'sd32767 : -a;
                end
                MODE_NEAR: begin
                    s = int'(a) + $urandom_range(64) - 32;
                    if (s > 32767)
                        s = 32767;
                    if (s < -32768)
                        s = -32768;
                    b = t_sample'(s);
                end
                MODE_ZERO_A: begin
                    a = '0;
                end
                MODE_ZERO_B: begin
                    b = '0;
                end
                MODE_TINY: begin
                    a = t_sample'($urandom_range(16) - 8);
                    b = t_sample'($urandom_range(16) - 8);
                end
                MODE_EXTREME: begin
                    case ($urandom_range(4))
                        0: a = -16'sd32768;
                        1: a = -16'sd1;
                        2: a = 16'sd0;
                        3: a = 16'sd1;
                        default: a = 16'sd32767;
                    endcase
                    case ($urandom_range(4))
                        0: b = -16'sd32768;
                        1: b = -16'sd1;
                        2: b = 16'sd0;
                        3: b = 16'sd1;
                        default: b = 16'sd32767;
                    endcase
                end
                default: begin
                end
            endcase
            put_pair(a, b, k == len - 1);
        end
    endtask

    // random vectors under one pressure setting; mostly short vectors
    task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
        int start;
        int r;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = pairs_sent;
        while (pairs_sent - start < items) begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(6, 1);
            else if (r < 95)
                len = $urandom_range(32, 7);
            else
                len = $urandom_range(100, 33);
            send_vector(len, t_vec_mode'($urandom_range(MODE_EXTREME)));
        end
    endtask

    initial begin
        int waited;
        rst_n             = 1'b0;
        done              = 1'b0;
        pair_if.valid     = 1'b0;
        pair_if.elem_a    = '0;
        pair_if.elem_b    = '0;
        pair_if.is_last   = 1'b0;
        result_if.ready   = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        pairs_sent        = 0;
        vectors_sent      = 0;

        // synchronous reset held low, then released after a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: plus one saturates, minus one is exact
        put_pair(16'sd32767, 16'sd32767, 1'b1);
        put_pair(-16'sd32768, -16'sd32768, 1'b1);
        put_pair(-16'sd32768, 16'sd32767, 1'b1);
        put_pair(-16'sd1, -16'sd1, 1'b1);
        put_pair(16'sd1, -16'sd1, 1'b1);
        // zero magnitude on either side or both
        put_pair(16'sd0, 16'sd0, 1'b1);
        put_pair(16'sd0, 16'sd5, 1'b1);
        put_pair(16'sd7, 16'sd0, 1'b1);
        put_pair(16'sd0, 16'sd0, 1'b0);
        put_pair(16'sd0, 16'sd0, 1'b0);
        put_pair(16'sd0, 16'sd0, 1'b1);
        // orthogonal vectors, dot of zero
        put_pair(16'sd1, 16'sd0, 1'b0);
        put_pair(16'sd0, 16'sd1, 1'b1);
        // mixed multi-element vectors
        put_pair(16'sd4096, -16'sd4096, 1'b0);
        put_pair(-16'sd1, 16'sd1, 1'b0);
        put_pair(16'sd32767, -16'sd32768, 1'b1);
        put_pair(16'sd1, 16'sd1, 1'b0);
        put_pair(16'sd1, -16'sd1, 1'b0);
        put_pair(16'sd3, 16'sd2, 1'b1);
        put_pair(16'sd12345, -16'sd2222, 1'b0);
        put_pair(-16'sd32768, 16'sd1, 1'b1);

        // random part over the pressure phases
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(77, 0, PHASE_ITEMS);
        run_phase(0, 77, PHASE_ITEMS);
        run_phase(33, 33, PHASE_ITEMS);

        pair_if.valid <= 1'b0;
        recv_stall_pct = 0;

        // drain outstanding results, then give stray ones time to show up
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(negedge clk);
            waited++;
        end
        repeat (120) @(negedge clk);
        done <= 1'b1;
        repeat (2) @(negedge clk);

        $display("covered %0d element pairs in %0d vectors, directed corners plus random shapes",
                 pairs_sent, vectors_sent);
        $display("checked %0d results (%0d degenerate) under four stall/idle mixes",
                 checked, degen_seen);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/cse_pkg.sv
rtl/core/cse_in_if.sv
rtl/core/cse_out_if.sv
rtl/core/cse_front.sv
rtl/core/cse_queue.sv
rtl/core/cse_back.sv
rtl/core/cosine_similarity_engine.sv
test/cse_result_checker.sv
test/tb.sv
